/* rtl/mmpq_pkg.sv */
// types and codes shared by the min/max priority queue
// request and result word layouts, action and status codes
// no dependencies
package mmpq_pkg;

    localparam logic [1:0] ACT_INSERT     = 2'd0;
    localparam logic [1:0] ACT_REMOVE_MIN = 2'd1;
    localparam logic [1:0] ACT_REMOVE_MAX = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic               now_empty;
    } result_t;

endpackage

/* rtl/min_max_priority_queue.sv */
// min_max_priority_queue: bounded double-ended priority queue over one memory
// depends on mmpq_pkg for the request and result word types and codes
//
// usage:
//   a request word is taken at a rising edge with start high and busy low:
//   insert a value, remove the smallest or remove the largest entry
//   every request gives exactly one result word, shown for one cycle with
//   done high; the receiver cannot stall it and must take it then
//   entries live in one synchronous memory of DEPTH words, each with an
//   occupied bit; a one-word scan through its single read port sets the rate
//   full insert, empty remove and unused action: result in the next cycle, and the
//   next request can be accepted in that same cycle
//   insert: the scan stops at the first free slot, which is then written
//   remove: every word is scanned, then the chosen entry is cleared; busy
//   stays high meanwhile, so a new request waits for the removal
//   busy is high while a request is in progress
//   after reset the memory is swept clear, one word a cycle, with busy high;
//   the queue is then empty
module min_max_priority_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mmpq_pkg::request_t request,
    output logic              done,
    output mmpq_pkg::result_t result
);
    import mmpq_pkg::*;

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int EXT = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam logic [DATA_WIDTH-1:0] SIGN_MASK = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_SPARE = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic                  issued_all_reg, issued_all_next;
    logic                  pend_reg, pend_next;
    logic [AW-1:0]         pend_addr_reg, pend_addr_next;
    logic [1:0]            op_reg, op_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [DATA_WIDTH-1:0] best_reg, best_next;
    logic [AW-1:0]         slot_reg, slot_next;
    logic                  have_reg, have_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;

    logic [DATA_WIDTH:0]   mem [DEPTH];
    logic [DATA_WIDTH:0]   rdata_reg;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH:0]   mem_wdata;

    logic signed [EXT-1:0] in_ext;
    logic [EXT-1:0]        out_ext;
    logic [DATA_WIDTH-1:0] rd_key;
    logic [DATA_WIDTH-1:0] best_key;
    logic                  take;
    logic                  issuing;

    assign in_ext   = EXT'(request.value);
    assign out_ext  = EXT'(best_reg);
    assign rd_key   = rdata_reg[DATA_WIDTH-1:0] ^ SIGN_MASK;
    assign best_key = best_reg ^ SIGN_MASK;
    assign take     = rdata_reg[DATA_WIDTH] &&
                      (!have_reg ||
                       ((op_reg == ACT_REMOVE_MAX) ? (rd_key > best_key) : (rd_key < best_key)));
    assign issuing  = (state_reg == ST_SCAN) && !issued_all_reg;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // entry memory: occupied bit on top of the stored value
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        issued_all_next = issued_all_reg;
        pend_next       = 1'b0;
        pend_addr_next  = addr_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        best_next       = best_reg;
        slot_next       = slot_reg;
        have_next       = have_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next         = request.action;
                    val_next        = in_ext[DATA_WIDTH-1:0];
                    addr_next       = '0;
                    issued_all_next = 1'b0;
                    have_next       = 1'b0;
                    result_next.out_value = '0;
                    unique case (request.action) inside
                        ACT_INSERT:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                done_next             = 1'b1;
                                result_next.status    = STATUS_FULL;
                                result_next.now_empty = 1'b0;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        ACT_REMOVE_MIN, ACT_REMOVE_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next             = 1'b1;
                                result_next.status    = STATUS_EMPTY;
                                result_next.now_empty = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next             = 1'b1;
                            result_next.status    = STATUS_OK;
                            result_next.now_empty = (count_reg == '0);
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // one read issued per cycle, data checked the cycle after
                if (issuing)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = addr_reg;
                    if (addr_reg == LAST_ADDR)
                    begin
                        issued_all_next = 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_reg + AW'(1);
                    end
                end
                if (pend_reg)
                begin
                    if (op_reg == ACT_INSERT)
                    begin
                        if (!rdata_reg[DATA_WIDTH])
                        begin
                            slot_next  = pend_addr_reg;
                            state_next = ST_WRITE;
                        end
                    end
                    else
                    begin
                        if (take)
                        begin
                            best_next = rdata_reg[DATA_WIDTH-1:0];
                            slot_next = pend_addr_reg;
                            have_next = 1'b1;
                        end
                        if (pend_addr_reg == LAST_ADDR)
                        begin
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = slot_reg;
                done_next  = 1'b1;
                addr_next  = '0;
                state_next = ST_IDLE;
                result_next.status = STATUS_OK;
                if (op_reg == ACT_INSERT)
                begin
                    mem_wdata             = {1'b1, val_reg};
                    count_next            = count_reg + CW'(1);
                    result_next.out_value = '0;
                    result_next.now_empty = 1'b0;
                end
                else
                begin
                    mem_wdata             = {1'b0, best_reg};
                    count_next            = count_reg - CW'(1);
                    result_next.out_value = out_ext[31:0];
                    result_next.now_empty = (count_reg == CW'(1));
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            issued_all_reg <= 1'b0;
            pend_reg       <= 1'b0;
            have_reg       <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            issued_all_reg <= issued_all_next;
            pend_reg       <= pend_next;
            have_reg       <= have_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        op_reg        <= op_next;
        val_reg       <= val_next;
        best_reg      <= best_next;
        slot_reg      <= slot_next;
        result_reg    <= result_next;
    end

endmodule

/* tb/tb_min_max_priority_queue.sv */
// self-checking testbench for min_max_priority_queue: directed table, then random words
// each result word is checked against its typed row or a local model of the bounded min/max queue
// depends on mmpq_pkg and the min_max_priority_queue rtl
module tb_min_max_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import mmpq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1750;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] value;
        logic [4:0]         reps;
        logic               typed;
        result_t            want;
    } stim_row_t;

    localparam result_t NO_WANT = '0;

    localparam int NUM_ROWS = 17;
    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{ACT_REMOVE_MIN, 32'sd0,           5'd1, 1'b1, '{STATUS_EMPTY, 32'sd0, 1'b1}},
        '{ACT_REMOVE_MAX, 32'sd0,           5'd1, 1'b1, '{STATUS_EMPTY, 32'sd0, 1'b1}},
        '{ACT_UNUSED,     32'sh7FFF_FFFF,   5'd1, 1'b1, '{STATUS_OK, 32'sd0, 1'b1}},
        '{ACT_INSERT,     32'sh7FFF_FFFF,   5'd1, 1'b1, '{STATUS_OK, 32'sd0, 1'b0}},
        '{ACT_INSERT,     32'sh8000_0000,   5'd1, 1'b1, '{STATUS_OK, 32'sd0, 1'b0}},
        '{ACT_REMOVE_MIN, 32'sd0,           5'd1, 1'b1, '{STATUS_OK, 32'sh8000_0000, 1'b0}},
        '{ACT_REMOVE_MAX, 32'sd0,           5'd1, 1'b1, '{STATUS_OK, 32'sh7FFF_FFFF, 1'b1}},
        '{ACT_INSERT,     -32'sd1,          5'd1, 1'b0, NO_WANT},
        '{ACT_INSERT,     32'sd5,           5'd7, 1'b0, NO_WANT},
        '{ACT_INSERT,     32'sh7FFF_FFFF,   5'd4, 1'b0, NO_WANT},
        '{ACT_INSERT,     32'sh8000_0000,   5'd4, 1'b0, NO_WANT},
        '{ACT_INSERT,     32'sd123,         5'd1, 1'b1, '{STATUS_FULL, 32'sd0, 1'b0}},
        '{ACT_UNUSED,     32'sd0,           5'd1, 1'b1, '{STATUS_OK, 32'sd0, 1'b0}},
        '{ACT_REMOVE_MAX, 32'sd0,           5'd1, 1'b1, '{STATUS_OK, 32'sh7FFF_FFFF, 1'b0}},
        '{ACT_INSERT,     32'sh5555_5555,   5'd1, 1'b0, NO_WANT},
        '{ACT_REMOVE_MIN, 32'sd0,           5'd3, 1'b0, NO_WANT},
        '{ACT_REMOVE_MAX, 32'sd0,           5'd2, 1'b0, NO_WANT}
    };

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    logic    row_typed;
    result_t row_want;

    logic signed [31:0] slot_value [QUEUE_DEPTH];
    logic               slot_used  [QUEUE_DEPTH];
    int                 used_count;

    result_t expected_results [$];
    result_t got_word;
    result_t want_word;
    result_t model_word;
    int      mismatch_count;
    int      idle_cycles;

    min_max_priority_queue dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic result_t queue_model(input request_t w);
        result_t res;
        int      pick;
        res = '0;
        res.status = STATUS_OK;
        pick = -1;
        case (w.action) inside
            ACT_INSERT:
            begin
                if (used_count >= QUEUE_DEPTH)
                begin
                    res.status = STATUS_FULL;
                end
                else
                begin
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (!slot_used[i] && pick < 0)
                        begin
                            pick = i;
                        end
                    end
                    slot_value[pick] = w.value;
                    slot_used[pick]  = 1'b1;
                    used_count++;
                end
            end
            ACT_REMOVE_MIN, ACT_REMOVE_MAX:
            begin
                if (used_count == 0)
                begin
                    res.status = STATUS_EMPTY;
                end
                else
                begin
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (slot_used[i])
                        begin
                            if (pick < 0)
                            begin
                                pick = i;
                            end
                            else if (w.action == ACT_REMOVE_MAX
                                     ? slot_value[i] > slot_value[pick]
                                     : slot_value[i] < slot_value[pick])
                            begin
                                pick = i;
                            end
                        end
                    end
                    res.out_value   = slot_value[pick];
                    slot_used[pick] = 1'b0;
                    used_count--;
                end
            end
            default:
            begin
            end
        endcase
        res.now_empty = (used_count == 0);
        return res;
    endfunction

    // result words first, then the request word taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                got_word = result;
                if (expected_results.size() == 0)
                begin
                    $error("result word with none expected: status %0d out_value %0d now_empty %0b",
                           got_word.status, got_word.out_value, got_word.now_empty);
                    mismatch_count++;
                end
                else
                begin
                    want_word = expected_results.pop_front();
                    if (got_word.status !== want_word.status)
                    begin
                        $error("status: expected %0d, got %0d", want_word.status, got_word.status);
                        mismatch_count++;
                    end
                    if (got_word.out_value !== want_word.out_value)
                    begin
                        $error("out_value: expected %0d, got %0d",
                               want_word.out_value, got_word.out_value);
                        mismatch_count++;
                    end
                    if (got_word.now_empty !== want_word.now_empty)
                    begin
                        $error("now_empty: expected %0b, got %0b",
                               want_word.now_empty, got_word.now_empty);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                model_word = queue_model(request);
                expected_results.push_back(row_typed ? row_want : model_word);
            end
            if (done || (start && !busy))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_word(input request_t w, input logic typed, input result_t want);
        start     <= 1'b1;
        request   <= w;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7)) inside
            0, 1:    return $signed($urandom_range(0, 8)) - 4;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        request_t w;
        int       sent;
        int       phase;
        int       phase_len;
        int       insert_pct;
        int       r;
        logic     quiet;

        rst_n          <= 1'b0;
        start          <= 1'b0;
        request        <= '0;
        row_typed      <= 1'b0;
        row_want       <= '0;
        used_count     = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_value[i] = '0;
            slot_used[i]  = 1'b0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[k])
        begin
            for (int n = 0; n < DIRECTED_ROWS[k].reps; n++)
            begin
                w.action = DIRECTED_ROWS[k].action;
                w.value  = DIRECTED_ROWS[k].value;
                send_word(w, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
                idle_gap(pick_gap(1'b0));
            end
        end
        wait_drained();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            phase_len = $urandom_range(30, 80);
            case ($urandom_range(0, 3))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    w.action = ACT_UNUSED;
                end
                else if (r < 3 + insert_pct)
                begin
                    w.action = ACT_INSERT;
                end
                else
                begin
                    w.action = $urandom_range(0, 1) ? ACT_REMOVE_MAX : ACT_REMOVE_MIN;
                end
                w.value = pick_value();
                send_word(w, 1'b0, NO_WANT);
                sent++;
                idle_gap(pick_gap(quiet));
            end
            phase++;
            if (phase % 6 == 0)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (QUEUE_DEPTH + 8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/mmpq_pkg.sv
rtl/min_max_priority_queue.sv
tb/tb_min_max_priority_queue.sv
